### hdl/rfl_pkg.sv
// ----------------------------------------------------------------------------
// rfl_pkg
// Shared types, register codes and arithmetic helpers for the reach force and
// torque law pipeline.
// ----------------------------------------------------------------------------
package rfl_pkg;

  localparam int unsigned DataW         = 32;
  localparam int unsigned CfgIdxW       = 3;
  localparam int unsigned RootSteps     = 32;
  localparam int unsigned QuotSteps     = 32;
  localparam int unsigned StepsPerStage = 2;
  localparam logic [DataW-1:0] GainReset = 32'd327680000;

  localparam logic [CfgIdxW-1:0] RegTargetX    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegTargetY    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegTargetZ    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegForceGain  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegTorqueGain = 3'd4;

  typedef struct packed {
    logic [31:0] marker_x;
    logic [31:0] marker_y;
    logic [31:0] marker_z;
    logic [31:0] normal_x;
    logic [31:0] normal_y;
    logic [31:0] normal_z;
  } in_t;

  typedef struct packed {
    logic [31:0] force_x;
    logic [31:0] force_y;
    logic [31:0] force_z;
    logic [31:0] torque_x;
    logic [31:0] torque_y;
    logic [31:0] torque_z;
    logic [31:0] error_x;
    logic [31:0] error_y;
    logic [31:0] error_z;
    logic        degenerate;
  } out_t;

  typedef logic [2:0][31:0] vec3_t;

  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] root;
    logic [63:0] rad;
  } sq_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] low;
    logic [31:0] q;
  } dv_t;

  typedef struct packed {
    vec3_t e;
    vec3_t n;
    vec3_t fcmd;
    sq_t   se;
    sq_t   sn;
  } sq_stage_t;

  typedef struct packed {
    vec3_t         e;
    vec3_t         fcmd;
    logic [31:0]   le;
    logic [31:0]   ln;
    logic          degen;
    dv_t [2:0]     de;
    dv_t [2:0]     dn;
  } dv_stage_t;

  typedef struct packed {
    vec3_t e;
    vec3_t fcmd;
    logic  degen;
  } side_t;

  function automatic logic [31:0] sub_sat(logic [31:0] a, logic [31:0] b);
    logic [32:0] d;
    d = {a[31], a} - {b[31], b};
    if (d[32] != d[31]) begin
      return d[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return d[31:0];
  endfunction

  function automatic logic [31:0] mag32(logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  function automatic logic [63:0] mag64(logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic logic [31:0] from_mag(logic neg, logic [63:0] m);
    if (neg) begin
      return (m >= 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - m[31:0]);
    end
    return (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
  endfunction

  // round half up of a magnitude over 2^30
  function automatic logic [33:0] rnd30(logic [63:0] m);
    logic [63:0] s;
    s = m + 64'h2000_0000;
    return s[63:30];
  endfunction

  function automatic sq_t sqrt_step(sq_t s);
    logic [33:0] t;
    logic [33:0] tst;
    sq_t         r;
    t     = {s.rem[31:0], s.rad[63:62]};
    tst   = {s.root, 2'b01};
    r.rad = {s.rad[61:0], 2'b00};
    if (t >= tst) begin
      r.rem  = t - tst;
      r.root = {s.root[30:0], 1'b1};
    end else begin
      r.rem  = t;
      r.root = {s.root[30:0], 1'b0};
    end
    return r;
  endfunction

  function automatic dv_t div_step(dv_t s, logic [31:0] len);
    logic [32:0] t;
    logic [32:0] diff;
    dv_t         r;
    t     = {s.rem, s.low[31]};
    diff  = t - {1'b0, len};
    r.low = {s.low[30:0], 1'b0};
    if (t >= {1'b0, len}) begin
      r.rem = diff[31:0];
      r.q   = {s.q[30:0], 1'b1};
    end else begin
      r.rem = t[31:0];
      r.q   = {s.q[30:0], 1'b0};
    end
    return r;
  endfunction

endpackage

### hdl/reach_force_torque_law.sv
// ----------------------------------------------------------------------------
// reach_force_torque_law
// Force and torque commands that pull a marker toward a configured target,
// with the torque turning the marker normal toward the error direction.
// ----------------------------------------------------------------------------
//  channel  | ports                              | handshake
//  ---------+------------------------------------+----------------------------
//  request  | start, busy, in_data               | taken when start && !busy
//  result   | out_strobe, out_data               | one cycle, cannot be held
//  config   | cfg_we, cfg_index, cfg_wdata       | written when cfg_we
//
//  one request per cycle, busy stays low
//  result strobes after stages a to c, the 16-stage square root and
//  16-stage divider pipelines, stages e to i and the output register
//  reset clears config to its defaults and empties the pipeline
//  no stalls: every stage advances each cycle
// ----------------------------------------------------------------------------
module reach_force_torque_law #(
  parameter int unsigned STEPS_PER_STAGE = rfl_pkg::StepsPerStage
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  rfl_pkg::in_t                 in_data,
  output logic                         out_strobe,
  output rfl_pkg::out_t                out_data,
  input  logic                         cfg_we,
  input  logic [rfl_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [rfl_pkg::DataW-1:0]    cfg_wdata
);

  localparam int unsigned SqStages = rfl_pkg::RootSteps / STEPS_PER_STAGE;
  localparam int unsigned DvStages = rfl_pkg::QuotSteps / STEPS_PER_STAGE;

  rfl_pkg::vec3_t tgt_r;
  logic [31:0]    fgain_r;
  logic [31:0]    tgain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r   <= '0;
      fgain_r <= rfl_pkg::GainReset;
      tgain_r <= rfl_pkg::GainReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rfl_pkg::RegTargetX:    tgt_r[0] <= cfg_wdata;
        rfl_pkg::RegTargetY:    tgt_r[1] <= cfg_wdata;
        rfl_pkg::RegTargetZ:    tgt_r[2] <= cfg_wdata;
        rfl_pkg::RegForceGain:  fgain_r  <= cfg_wdata;
        rfl_pkg::RegTorqueGain: tgain_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // error and normal
  rfl_pkg::vec3_t mk;
  rfl_pkg::vec3_t a_n_nxt, a_e_nxt;
  rfl_pkg::vec3_t a_n_r, a_e_r;
  logic           a_v_r;

  always_comb begin
    mk      = {in_data.marker_z, in_data.marker_y, in_data.marker_x};
    a_n_nxt = {in_data.normal_z, in_data.normal_y, in_data.normal_x};
    for (int i = 0; i < 3; i++) begin
      a_e_nxt[i] = rfl_pkg::sub_sat(tgt_r[i], mk[i]);
    end
  end

  always_ff @(posedge clk) begin
    a_e_r <= a_e_nxt;
    a_n_r <= a_n_nxt;
  end

  // squares and force products
  logic [2:0][63:0] b_sqe_nxt, b_sqn_nxt, b_fp_nxt;
  logic [2:0][63:0] b_sqe_r, b_sqn_r, b_fp_r;
  rfl_pkg::vec3_t   em, nmg;
  rfl_pkg::vec3_t   b_e_r, b_n_r;
  logic             b_v_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      em[i]        = rfl_pkg::mag32(a_e_r[i]);
      nmg[i]       = rfl_pkg::mag32(a_n_r[i]);
      b_sqe_nxt[i] = {32'd0, em[i]} * {32'd0, em[i]};
      b_sqn_nxt[i] = {32'd0, nmg[i]} * {32'd0, nmg[i]};
      b_fp_nxt[i]  = {32'd0, fgain_r} * {32'd0, em[i]};
    end
  end

  always_ff @(posedge clk) begin
    b_sqe_r <= b_sqe_nxt;
    b_sqn_r <= b_sqn_nxt;
    b_fp_r  <= b_fp_nxt;
    b_e_r   <= a_e_r;
    b_n_r   <= a_n_r;
  end

  // sums and force rounding
  logic [63:0]    c_se_nxt, c_sn_nxt, c_se_r, c_sn_r;
  rfl_pkg::vec3_t c_force_nxt, c_force_r, c_e_r, c_n_r;
  logic           c_v_r;

  always_comb begin
    c_se_nxt = b_sqe_r[0] + b_sqe_r[1] + b_sqe_r[2];
    c_sn_nxt = b_sqn_r[0] + b_sqn_r[1] + b_sqn_r[2];
    for (int i = 0; i < 3; i++) begin
      c_force_nxt[i] = rfl_pkg::from_mag(b_e_r[i][31], (b_fp_r[i] + 64'd32768) >> 16);
    end
  end

  always_ff @(posedge clk) begin
    c_se_r    <= c_se_nxt;
    c_sn_r    <= c_sn_nxt;
    c_force_r <= c_force_nxt;
    c_e_r     <= b_e_r;
    c_n_r     <= b_n_r;
  end

  // square root pipeline
  rfl_pkg::sq_stage_t sq_in [SqStages];
  rfl_pkg::sq_stage_t sq_r  [SqStages];
  logic               sq_v_r [SqStages];

  always_comb begin
    sq_in[0].e       = c_e_r;
    sq_in[0].n       = c_n_r;
    sq_in[0].fcmd    = c_force_r;
    sq_in[0].se.rem  = '0;
    sq_in[0].se.root = '0;
    sq_in[0].se.rad  = c_se_r;
    sq_in[0].sn.rem  = '0;
    sq_in[0].sn.root = '0;
    sq_in[0].sn.rad  = c_sn_r;
  end

  for (genvar g = 1; g < SqStages; g++) begin : g_sq_link
    assign sq_in[g] = sq_r[g-1];
  end

  for (genvar g = 0; g < SqStages; g++) begin : g_sq
    rfl_pkg::sq_stage_t sq_nxt;
    always_comb begin
      sq_nxt = sq_in[g];
      for (int k = 0; k < STEPS_PER_STAGE; k++) begin
        sq_nxt.se = rfl_pkg::sqrt_step(sq_nxt.se);
        sq_nxt.sn = rfl_pkg::sqrt_step(sq_nxt.sn);
      end
    end
    always_ff @(posedge clk) begin
      sq_r[g] <= sq_nxt;
    end
  end

  // divider pipeline
  rfl_pkg::sq_stage_t sq_last;
  rfl_pkg::dv_stage_t dv_in [DvStages];
  rfl_pkg::dv_stage_t dv_r  [DvStages];
  logic               dv_v_r [DvStages];
  logic [63:0]        ne [3];
  logic [63:0]        nn [3];

  assign sq_last = sq_r[SqStages-1];

  always_comb begin
    dv_in[0].e     = sq_last.e;
    dv_in[0].fcmd  = sq_last.fcmd;
    dv_in[0].le    = sq_last.se.root;
    dv_in[0].ln    = sq_last.sn.root;
    dv_in[0].degen = (sq_last.se.root == '0) || (sq_last.sn.root == '0);
    for (int i = 0; i < 3; i++) begin
      ne[i] = ({32'd0, rfl_pkg::mag32(sq_last.e[i])} << 30)
            + {33'd0, sq_last.se.root[31:1]};
      nn[i] = ({32'd0, rfl_pkg::mag32(sq_last.n[i])} << 30)
            + {33'd0, sq_last.sn.root[31:1]};
      dv_in[0].de[i].rem = ne[i][63:32];
      dv_in[0].de[i].low = ne[i][31:0];
      dv_in[0].de[i].q   = '0;
      dv_in[0].dn[i].rem = nn[i][63:32];
      dv_in[0].dn[i].low = nn[i][31:0];
      dv_in[0].dn[i].q   = '0;
    end
  end

  for (genvar g = 1; g < DvStages; g++) begin : g_dv_link
    assign dv_in[g] = dv_r[g-1];
  end

  for (genvar g = 0; g < DvStages; g++) begin : g_dv
    rfl_pkg::dv_stage_t dv_nxt;
    always_comb begin
      dv_nxt = dv_in[g];
      for (int k = 0; k < STEPS_PER_STAGE; k++) begin
        for (int i = 0; i < 3; i++) begin
          dv_nxt.de[i] = rfl_pkg::div_step(dv_nxt.de[i], dv_nxt.le);
          dv_nxt.dn[i] = rfl_pkg::div_step(dv_nxt.dn[i], dv_nxt.ln);
        end
      end
    end
    always_ff @(posedge clk) begin
      dv_r[g] <= dv_nxt;
    end
  end

  // cross and dot products
  rfl_pkg::dv_stage_t dv_last;
  rfl_pkg::vec3_t     sn_dir;
  logic signed [31:0] ue [3];
  logic signed [31:0] un [3];
  logic signed [63:0] e_pa_nxt [3];
  logic signed [63:0] e_pb_nxt [3];
  logic signed [63:0] e_pd_nxt [3];
  logic signed [63:0] e_pa_r [3];
  logic signed [63:0] e_pb_r [3];
  logic signed [63:0] e_pd_r [3];
  logic [63:0]        e_gl_nxt, e_gl_r;
  rfl_pkg::side_t     e_sd_r;
  logic               e_v_r;

  assign dv_last = dv_r[DvStages-1];
  assign sn_dir  = sq_r[SqStages-1].n;

  rfl_pkg::vec3_t dv_n_r [DvStages];

  always_ff @(posedge clk) begin
    dv_n_r[0] <= sn_dir;
    for (int k = 1; k < DvStages; k++) begin
      dv_n_r[k] <= dv_n_r[k-1];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ue[i] = dv_last.e[i][31] ? (32'd0 - dv_last.de[i].q) : dv_last.de[i].q;
      un[i] = dv_n_r[DvStages-1][i][31] ? (32'd0 - dv_last.dn[i].q) : dv_last.dn[i].q;
      e_pd_nxt[i] = un[i] * ue[i];
    end
    e_pa_nxt[0] = un[1] * ue[2];
    e_pb_nxt[0] = un[2] * ue[1];
    e_pa_nxt[1] = un[2] * ue[0];
    e_pb_nxt[1] = un[0] * ue[2];
    e_pa_nxt[2] = un[0] * ue[1];
    e_pb_nxt[2] = un[1] * ue[0];
    e_gl_nxt    = {32'd0, tgain_r} * {32'd0, dv_last.le};
  end

  always_ff @(posedge clk) begin
    e_pa_r       <= e_pa_nxt;
    e_pb_r       <= e_pb_nxt;
    e_pd_r       <= e_pd_nxt;
    e_gl_r       <= e_gl_nxt;
    e_sd_r.e     <= dv_last.e;
    e_sd_r.fcmd  <= dv_last.fcmd;
    e_sd_r.degen <= dv_last.degen;
  end

  // cross rounding and angle factor
  logic [63:0]    cx [3];
  logic [33:0]    cmr [3];
  logic [63:0]    ds;
  logic [33:0]    dm;
  logic [34:0]    dsgn, a2w;
  logic [2:0][31:0] f_cm_nxt, f_cm_r;
  logic [2:0]     f_cn_nxt, f_cn_r;
  logic [31:0]    f_a2_nxt, f_a2_r;
  logic [63:0]    f_gl_r;
  rfl_pkg::side_t f_sd_r;
  logic           f_v_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cx[i]       = e_pa_r[i] - e_pb_r[i];
      cmr[i]      = rfl_pkg::rnd30(rfl_pkg::mag64(cx[i]));
      f_cm_nxt[i] = cmr[i][31:0];
      f_cn_nxt[i] = cx[i][63];
    end
    ds   = e_pd_r[0] + e_pd_r[1] + e_pd_r[2];
    dm   = rfl_pkg::rnd30(rfl_pkg::mag64(ds));
    dsgn = ds[63] ? (35'd0 - {1'b0, dm}) : {1'b0, dm};
    a2w  = 35'h0_4000_0000 - dsgn;
    if (a2w[34]) begin
      f_a2_nxt = '0;
    end else if (a2w[33:0] > 34'h0_8000_0000) begin
      f_a2_nxt = 32'h8000_0000;
    end else begin
      f_a2_nxt = a2w[31:0];
    end
  end

  always_ff @(posedge clk) begin
    f_cm_r <= f_cm_nxt;
    f_cn_r <= f_cn_nxt;
    f_a2_r <= f_a2_nxt;
    f_gl_r <= e_gl_r;
    f_sd_r <= e_sd_r;
  end

  // angle factor times cross
  logic [2:0][63:0] g_pk_nxt, g_pk_r;
  logic [2:0]       g_cn_r;
  logic [63:0]      g_gl_r;
  rfl_pkg::side_t   g_sd_r;
  logic             g_v_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      g_pk_nxt[i] = {32'd0, f_a2_r} * {32'd0, f_cm_r[i]};
    end
  end

  always_ff @(posedge clk) begin
    g_pk_r <= g_pk_nxt;
    g_cn_r <= f_cn_r;
    g_gl_r <= f_gl_r;
    g_sd_r <= f_sd_r;
  end

  // round and clamp k
  logic [33:0]      kr [3];
  logic [2:0][31:0] h_km_nxt, h_km_r;
  logic [2:0]       h_cn_r;
  logic [63:0]      h_gl_r;
  rfl_pkg::side_t   h_sd_r;
  logic             h_v_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      kr[i]       = rfl_pkg::rnd30(g_pk_r[i]);
      h_km_nxt[i] = (kr[i] > 34'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : kr[i][31:0];
    end
  end

  always_ff @(posedge clk) begin
    h_km_r <= h_km_nxt;
    h_cn_r <= g_cn_r;
    h_gl_r <= g_gl_r;
    h_sd_r <= g_sd_r;
  end

  // gain-length partial products
  logic [2:0][63:0] i_lo_nxt, i_hi_nxt, i_lo_r, i_hi_r;
  logic [2:0]       i_cn_r;
  rfl_pkg::side_t   i_sd_r;
  logic             i_v_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      i_lo_nxt[i] = {32'd0, h_gl_r[31:0]} * {32'd0, h_km_r[i]};
      i_hi_nxt[i] = {32'd0, h_gl_r[63:32]} * {32'd0, h_km_r[i]};
    end
  end

  always_ff @(posedge clk) begin
    i_lo_r <= i_lo_nxt;
    i_hi_r <= i_hi_nxt;
    i_cn_r <= h_cn_r;
    i_sd_r <= h_sd_r;
  end

  // torque rounding and result
  logic [95:0]      pp [3];
  logic [96:0]      pr [3];
  logic [63:0]      tm [3];
  rfl_pkg::vec3_t   tq;
  rfl_pkg::out_t    out_data_nxt, out_data_r;
  logic             out_strobe_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pp[i] = {32'd0, i_lo_r[i]} + {i_hi_r[i], 32'd0};
      pr[i] = {1'b0, pp[i]} + (97'd1 << 46);
      tm[i] = (pr[i][96:79] != '0) ? 64'h2_0000_0000 : {32'd0, pr[i][78:47]};
      tq[i] = i_sd_r.degen ? 32'd0 : rfl_pkg::from_mag(i_cn_r[i], tm[i]);
    end
    out_data_nxt.force_x    = i_sd_r.fcmd[0];
    out_data_nxt.force_y    = i_sd_r.fcmd[1];
    out_data_nxt.force_z    = i_sd_r.fcmd[2];
    out_data_nxt.torque_x   = tq[0];
    out_data_nxt.torque_y   = tq[1];
    out_data_nxt.torque_z   = tq[2];
    out_data_nxt.error_x    = i_sd_r.e[0];
    out_data_nxt.error_y    = i_sd_r.e[1];
    out_data_nxt.error_z    = i_sd_r.e[2];
    out_data_nxt.degenerate = i_sd_r.degen;
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r        <= 1'b0;
      b_v_r        <= 1'b0;
      c_v_r        <= 1'b0;
      e_v_r        <= 1'b0;
      f_v_r        <= 1'b0;
      g_v_r        <= 1'b0;
      h_v_r        <= 1'b0;
      i_v_r        <= 1'b0;
      out_strobe_r <= 1'b0;
      for (int k = 0; k < SqStages; k++) begin
        sq_v_r[k] <= 1'b0;
      end
      for (int k = 0; k < DvStages; k++) begin
        dv_v_r[k] <= 1'b0;
      end
    end else begin
      a_v_r     <= start && !busy;
      b_v_r     <= a_v_r;
      c_v_r     <= b_v_r;
      sq_v_r[0] <= c_v_r;
      for (int k = 1; k < SqStages; k++) begin
        sq_v_r[k] <= sq_v_r[k-1];
      end
      dv_v_r[0] <= sq_v_r[SqStages-1];
      for (int k = 1; k < DvStages; k++) begin
        dv_v_r[k] <= dv_v_r[k-1];
      end
      e_v_r        <= dv_v_r[DvStages-1];
      f_v_r        <= e_v_r;
      g_v_r        <= f_v_r;
      h_v_r        <= g_v_r;
      i_v_r        <= h_v_r;
      out_strobe_r <= i_v_r;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  a_degen_torque_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.degenerate) |->
      (out_data.torque_x == '0 && out_data.torque_y == '0 && out_data.torque_z == '0))
    else $error("torque not zero on degenerate result");

  a_force_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.force_x != '0) |-> (out_data.force_x[31] == out_data.error_x[31]))
    else $error("force sign differs from error sign");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    f_v_r |-> (f_a2_r <= 32'h8000_0000))
    else $error("angle factor out of range");

  a_unit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_v_r[DvStages-1] && !dv_last.degen) |->
      (dv_last.de[0].q <= 32'h4000_0000 && dv_last.dn[0].q <= 32'h4000_0000))
    else $error("unit vector component above one");

endmodule
